/* design/rtp_depacketizer_loss_counter_core_defines.svh */
// Assertion macros for the RTP depacketizer core.
// Included by the top level; no other dependencies.
`ifndef RTP_DEPACKETIZER_LOSS_COUNTER_CORE_DEFINES_SVH
`define RTP_DEPACKETIZER_LOSS_COUNTER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define RTPD_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtpd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RTPD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtpd assertion failed");
`else
`define RTPD_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define RTPD_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* design/rtpd_pkg.sv */
// Shared types and constants of the RTP depacketizer core.
// No dependencies; rtpd_out_if, the parser, stats and top level use it.
package rtpd_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65536;
    localparam int COUNTER_BITS_DEF     = 32;

    localparam int FIXED_HDR   = 12;
    localparam int RTP_VERSION = 2;
    localparam int HDR_W       = 19;
    localparam int SIZE_W      = 17;
    localparam int SEQ_W       = 16;
    localparam int TS_W        = 32;
    localparam int CNT_OUT_W   = 32;
    localparam int BYTE_CNT_W  = 48;
    localparam int REASON_W    = 3;

    typedef enum logic [REASON_W-1:0] {
        DROP_NONE       = 3'd0,
        DROP_SHORT      = 3'd1,
        DROP_VERSION    = 3'd2,
        DROP_EXT_TRUNC  = 3'd3,
        DROP_NO_PAYLOAD = 3'd4
    } drop_reason_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_DROP    = 1'b1
    } kind_t;

    // Packet completion event from the parser to the statistics unit.
    typedef struct packed {
        logic              count_en;
        logic [SIZE_W-1:0] size;
        logic [SEQ_W-1:0]  seq;
    } pkt_event_t;

    // Per-word parse result, before the counters are attached.
    typedef struct packed {
        logic             emit;
        kind_t            kind;
        logic [7:0]       payload_byte;
        logic             first_payload;
        logic             last_payload;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        drop_reason_t     reason;
    } parse_res_t;

    // Counter values after the current word's update.
    typedef struct packed {
        logic [CNT_OUT_W-1:0]  packets;
        logic [BYTE_CNT_W-1:0] bytes;
        logic [CNT_OUT_W-1:0]  lost;
        logic [CNT_OUT_W-1:0]  reorder;
    } stats_t;

endpackage

/* design/rtpd_in_if.sv */
// Input channel of the RTP depacketizer: one datagram byte per word.
// Depends on nothing.
interface rtpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/rtpd_out_if.sv */
// Result channel of the RTP depacketizer: payload bytes and drop notices.
// Depends on rtpd_pkg for field widths.
interface rtpd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [7:0]                      payload_byte;
    logic                            first_payload;
    logic                            last_payload;
    logic [rtpd_pkg::SEQ_W-1:0]      sequence_number;
    logic [rtpd_pkg::TS_W-1:0]       rtp_timestamp;
    logic [rtpd_pkg::REASON_W-1:0]   drop_reason;
    logic [rtpd_pkg::CNT_OUT_W-1:0]  rx_packets;
    logic [rtpd_pkg::BYTE_CNT_W-1:0] rx_bytes;
    logic [rtpd_pkg::CNT_OUT_W-1:0]  rx_lost;
    logic [rtpd_pkg::CNT_OUT_W-1:0]  rx_reordered;

    modport source (
        output valid, output kind, output payload_byte, output first_payload,
        output last_payload, output sequence_number, output rtp_timestamp,
        output drop_reason, output rx_packets, output rx_bytes,
        output rx_lost, output rx_reordered, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input first_payload,
        input last_payload, input sequence_number, input rtp_timestamp,
        input drop_reason, input rx_packets, input rx_bytes,
        input rx_lost, input rx_reordered, output ready
    );
endinterface

/* design/rtpd_in_stage.sv */
// Input register of the RTP depacketizer; holds one byte word.
// Depends on rtpd_in_if.
module rtpd_in_stage (
    input  logic        clk,
    input  logic        rst_n,
    rtpd_in_if.sink     datagram,
    input  logic        advance,
    output logic        in_valid,
    output logic [7:0]  data_byte,
    output logic        last_byte
);
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // The register can take a word when empty or when its word moves on.
    assign datagram.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (datagram.ready)
        begin
            in_valid_next = datagram.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (datagram.valid && datagram.ready)
        begin
            byte_reg <= datagram.data_byte;
            last_reg <= datagram.last_byte;
        end
    end

    assign in_valid  = in_valid_reg;
    assign data_byte = byte_reg;
    assign last_byte = last_reg;
endmodule

/* design/rtpd_parser.sv */
// Header parser of the RTP depacketizer: byte offset, header fields, drop checks.
// Depends on rtpd_pkg.
module rtpd_parser #(
    parameter int MAX_PACKET_BYTES = rtpd_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   advance,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output rtpd_pkg::parse_res_t   res,
    output rtpd_pkg::pkt_event_t   ev
);
    import rtpd_pkg::*;

    localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [OFF_W-1:0] MAX_OFF  = OFF_W'(MAX_PACKET_BYTES);
    localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(MAX_PACKET_BYTES - 1);

    logic [OFF_W-1:0] off_reg,     off_next;
    logic [HDR_W-1:0] hdr_len_reg, hdr_len_next;
    logic [3:0]       csrc_reg,    csrc_next;
    logic             ext_reg,     ext_next;
    logic             bad_reg,     bad_next;
    logic [SEQ_W-1:0] seq_reg,     seq_next;
    logic [TS_W-1:0]  ts_reg,      ts_next;
    logic [7:0]       ext_hi_reg,  ext_hi_next;

    logic [HDR_W-1:0]  off_ext;
    logic [HDR_W-1:0]  csrc_end;
    logic [SIZE_W-1:0] size;
    logic [HDR_W-1:0]  size_ext;
    logic              is_first;
    logic              overflow;
    logic              ending;
    drop_reason_t      reason;

    // Next header state and result for the word in the input register.
    always_comb
    begin
        off_next     = off_reg;
        hdr_len_next = hdr_len_reg;
        csrc_next    = csrc_reg;
        ext_next     = ext_reg;
        bad_next     = bad_reg;
        seq_next     = seq_reg;
        ts_next      = ts_reg;
        ext_hi_next  = ext_hi_reg;
        res          = '0;
        ev           = '0;
        reason       = DROP_NONE;

        off_ext  = HDR_W'(off_reg);
        is_first = (off_reg == '0);
        overflow = (off_reg >= MAX_OFF);
        size     = SIZE_W'(off_reg) + SIZE_W'(1);
        size_ext = HDR_W'(size);
        ending   = last_byte || (off_reg == LAST_OFF);

        // First byte: version, X bit and CSRC count.
        if (is_first)
        begin
            csrc_next   = data_byte[3:0];
            ext_next    = data_byte[4];
            bad_next    = (data_byte[7:6] != 2'(RTP_VERSION));
            seq_next    = '0;
            ts_next     = '0;
            ext_hi_next = '0;
        end
        else if (off_reg == OFF_W'(2))
        begin
            seq_next = {data_byte, 8'h00};
        end
        else if (off_reg == OFF_W'(3))
        begin
            seq_next = {seq_reg[15:8], data_byte};
        end
        else if (off_reg >= OFF_W'(4) && off_reg <= OFF_W'(7))
        begin
            ts_next = {ts_reg[23:0], data_byte};
        end

        csrc_end = HDR_W'(FIXED_HDR) + HDR_W'({csrc_next, 2'b00});
        if (is_first)
        begin
            hdr_len_next = csrc_end + (ext_next ? HDR_W'(4) : HDR_W'(0));
        end

        // Extension header length word, big endian, in 32-bit words.
        if (ext_next && off_ext == csrc_end + HDR_W'(2))
        begin
            ext_hi_next = data_byte;
        end
        else if (ext_next && off_ext == csrc_end + HDR_W'(3))
        begin
            hdr_len_next = csrc_end + HDR_W'(4) + HDR_W'({ext_hi_reg, data_byte, 2'b00});
        end

        // Drop checks in priority order.
        if (size < SIZE_W'(FIXED_HDR))
        begin
            reason = DROP_SHORT;
        end
        else if (bad_next)
        begin
            reason = DROP_VERSION;
        end
        else if (ext_next && size_ext < csrc_end + HDR_W'(4))
        begin
            reason = DROP_EXT_TRUNC;
        end
        else if (size_ext <= hdr_len_next)
        begin
            reason = DROP_NO_PAYLOAD;
        end

        if (overflow)
        begin
            // Oversize tail: swallow bytes until the marked last one.
            off_next     = last_byte ? '0 : off_reg;
            hdr_len_next = hdr_len_reg;
            csrc_next    = csrc_reg;
            ext_next     = ext_reg;
            bad_next     = bad_reg;
            seq_next     = seq_reg;
            ts_next      = ts_reg;
            ext_hi_next  = ext_hi_reg;
        end
        else if (!ending)
        begin
            off_next = off_reg + OFF_W'(1);
            if (!bad_next && off_ext >= hdr_len_next)
            begin
                res.emit          = in_valid;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = data_byte;
                res.first_payload = (off_ext == hdr_len_next);
            end
        end
        else
        begin
            off_next = last_byte ? '0 : MAX_OFF;
            res.emit = in_valid;
            if (reason != DROP_NONE)
            begin
                res.kind = KIND_DROP;
            end
            else
            begin
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = data_byte;
                res.first_payload = (off_ext == hdr_len_next);
                res.last_payload  = 1'b1;
                ev.count_en       = in_valid;
                ev.size           = size;
                ev.seq            = seq_next;
            end
        end

        res.reason = reason;
        res.seq    = seq_next;
        res.ts     = ts_next;
        if (res.kind == KIND_PAYLOAD)
        begin
            res.reason = DROP_NONE;
        end
    end

    // Control state: offset and header bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg     <= '0;
            hdr_len_reg <= HDR_W'(FIXED_HDR);
            csrc_reg    <= '0;
            ext_reg     <= 1'b0;
            bad_reg     <= 1'b0;
            seq_reg     <= '0;
            ts_reg      <= '0;
            ext_hi_reg  <= '0;
        end
        else if (advance)
        begin
            off_reg     <= off_next;
            hdr_len_reg <= hdr_len_next;
            csrc_reg    <= csrc_next;
            ext_reg     <= ext_next;
            bad_reg     <= bad_next;
            seq_reg     <= seq_next;
            ts_reg      <= ts_next;
            ext_hi_reg  <= ext_hi_next;
        end
    end
endmodule

/* design/rtpd_stats.sv */
// Reception statistics of the RTP depacketizer: saturating packet, byte,
// loss and reorder counters. Depends on rtpd_pkg.
module rtpd_stats #(
    parameter int COUNTER_BITS = rtpd_pkg::COUNTER_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  rtpd_pkg::pkt_event_t ev,
    output rtpd_pkg::stats_t     stats
);
    import rtpd_pkg::*;

    // Packet, loss and reorder counters never exceed the 32-bit result fields.
    localparam int CNT_W = (COUNTER_BITS < CNT_OUT_W) ? COUNTER_BITS : CNT_OUT_W;
    localparam int SUM_W = CNT_W + 1;
    localparam int BSUM_W = BYTE_CNT_W + 1;

    logic [CNT_W-1:0]      packets_reg, packets_next;
    logic [BYTE_CNT_W-1:0] bytes_reg,   bytes_next;
    logic [CNT_W-1:0]      lost_reg,    lost_next;
    logic [CNT_W-1:0]      reorder_reg, reorder_next;
    logic [SEQ_W-1:0]      prev_seq_reg, prev_seq_next;
    logic                  prev_valid_reg, prev_valid_next;

    logic [SEQ_W-1:0]  gap;
    logic [SUM_W-1:0]  packets_sum;
    logic [BSUM_W-1:0] bytes_sum;
    logic [SUM_W-1:0]  lost_sum;
    logic [SUM_W-1:0]  reorder_sum;

    // Saturating updates: a carry out of the counter width sticks at the maximum.
    always_comb
    begin
        packets_next    = packets_reg;
        bytes_next      = bytes_reg;
        lost_next       = lost_reg;
        reorder_next    = reorder_reg;
        prev_seq_next   = prev_seq_reg;
        prev_valid_next = prev_valid_reg;

        gap         = ev.seq - prev_seq_reg - SEQ_W'(1);
        packets_sum = {1'b0, packets_reg} + SUM_W'(1);
        bytes_sum   = {1'b0, bytes_reg} + BSUM_W'(ev.size);
        lost_sum    = {1'b0, lost_reg} + SUM_W'(gap);
        reorder_sum = {1'b0, reorder_reg} + SUM_W'(1);

        if (ev.count_en)
        begin
            packets_next = packets_sum[SUM_W-1] ? packets_reg : packets_sum[CNT_W-1:0];
            bytes_next   = bytes_sum[BSUM_W-1] ? '1 : bytes_sum[BYTE_CNT_W-1:0];
            if (prev_valid_reg)
            begin
                if (gap != '0 && !gap[SEQ_W-1])
                begin
                    lost_next = lost_sum[SUM_W-1] ? '1 : lost_sum[CNT_W-1:0];
                end
                else if (gap[SEQ_W-1] && gap != '1)
                begin
                    reorder_next = reorder_sum[SUM_W-1] ? reorder_reg
                                                        : reorder_sum[CNT_W-1:0];
                end
            end
            prev_seq_next   = ev.seq;
            prev_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packets_reg    <= '0;
            bytes_reg      <= '0;
            lost_reg       <= '0;
            reorder_reg    <= '0;
            prev_seq_reg   <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            packets_reg    <= packets_next;
            bytes_reg      <= bytes_next;
            lost_reg       <= lost_next;
            reorder_reg    <= reorder_next;
            prev_seq_reg   <= prev_seq_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    // The result word shows the values after this word's update.
    assign stats.packets = CNT_OUT_W'(packets_next);
    assign stats.bytes   = bytes_next;
    assign stats.lost    = CNT_OUT_W'(lost_next);
    assign stats.reorder = CNT_OUT_W'(reorder_next);
endmodule

/* design/rtp_depacketizer_loss_counter_core.sv */
// Top level of the RTP depacketizer with loss counters.
// Depends on rtpd_pkg, rtpd_in_if, rtpd_out_if, rtpd_in_stage, rtpd_parser,
// rtpd_stats and the assertion macro header.
//
//  Channel  | Dir | Word
//  ---------+-----+---------------------------------------------------------
//  datagram | in  | data_byte, last_byte: one datagram byte
//  result   | out | payload byte or drop notice, header fields, counters
//
// One word per cycle is accepted while the result register drains; a result word
// passes through the input register and then the result register to the output.
// A word is parsed in the cycle after acceptance, between the input register
// and the result register; a word that gives no result still takes that cycle.
// A stall at the output holds both registers; input ready falls once both are full.
// Reset is asynchronous and active low; it clears offset, header state and
// all counters, and no clearing pass follows.
module rtp_depacketizer_loss_counter_core #(
    parameter int MAX_PACKET_BYTES = rtpd_pkg::MAX_PACKET_BYTES_DEF,
    parameter int COUNTER_BITS     = rtpd_pkg::COUNTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rtpd_in_if.sink     datagram,
    rtpd_out_if.source  result
);
    import rtpd_pkg::*;

    `include "rtp_depacketizer_loss_counter_core_defines.svh"

    logic       in_valid;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       advance;
    logic       res_load;
    parse_res_t res;
    pkt_event_t ev;
    stats_t     stats;

    logic       res_valid_reg, res_valid_next;
    parse_res_t res_reg;
    stats_t     stats_reg;

    // The word in the input register moves on when the result slot is free.
    assign advance  = in_valid && (!res_valid_reg || result.ready);
    assign res_load = advance && res.emit;

    rtpd_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .datagram  (datagram),
        .advance   (advance),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .last_byte (last_byte)
    );

    rtpd_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .advance   (advance),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res       (res),
        .ev        (ev)
    );

    rtpd_stats #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_stats (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ev      (ev),
        .stats   (stats)
    );

    // Result register valid flag.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg   <= res;
            stats_reg <= stats;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.kind            = res_reg.kind;
    assign result.payload_byte    = res_reg.payload_byte;
    assign result.first_payload   = res_reg.first_payload;
    assign result.last_payload    = res_reg.last_payload;
    assign result.sequence_number = res_reg.seq;
    assign result.rtp_timestamp   = res_reg.ts;
    assign result.drop_reason     = res_reg.reason;
    assign result.rx_packets      = stats_reg.packets;
    assign result.rx_bytes        = stats_reg.bytes;
    assign result.rx_lost         = stats_reg.lost;
    assign result.rx_reordered    = stats_reg.reorder;

    // A new result never overwrites one that has not been taken.
    `RTPD_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, res_load, !res_valid_reg || result.ready)
    // A drop notice carries a reason and no payload marks.
    `RTPD_ASSERT_IMPLY(a_drop_word, clk, rst_n, result.valid && result.kind,
        (result.drop_reason != DROP_NONE) && !result.first_payload
        && !result.last_payload && (result.payload_byte == 8'd0))
    // An accepted input word is held in the input register next cycle.
    `RTPD_ASSERT_NEXT(a_in_capture, clk, rst_n, datagram.valid && datagram.ready, in_valid)
endmodule
